@@ hw/rtl/sicp_pkg.sv @@
`timescale 1ns / 1ps

package sicp_pkg;

  localparam int NumRegs = 29;
  localparam int IdxW    = 5;

  // access codes
  localparam logic ActRead   = 1'b0;
  localparam logic ActWrite  = 1'b1;
  localparam logic PortIndex = 1'b0;
  localparam logic PortData  = 1'b1;

  // register indexes
  localparam logic [IdxW-1:0] IdReg      = 5'd8;
  localparam logic [IdxW-1:0] LockReg    = 5'd2;
  localparam logic [IdxW-1:0] LptBaseReg = 5'd25;
  localparam logic [IdxW-1:0] LptCtlReg  = 5'd27;
  localparam logic [IdxW-1:0] ReadLimit  = 5'd28;
  localparam logic [IdxW-1:0] WriteLimit = 5'd28;

  localparam logic [7:0] IdValue      = 8'h71;
  localparam logic [7:0] IdxFirstRead = 8'h88;
  localparam logic [7:0] Reg25Default = 8'hef;
  localparam logic [7:0] IdleByte     = 8'hff;
  localparam int         LockBit      = 6;

  typedef logic [7:0] cfg_file_t [NumRegs];

  localparam cfg_file_t CfgReset = '{
    8'h0b, 8'h01, 8'h00, 8'h01, 8'h00, 8'h0d, 8'h00, 8'h00,
    8'h71, 8'hc0, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h1e,
    8'h00, 8'h00, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'hef, 8'h00, 8'h00, 8'h00
  };

  // I/O bases
  localparam logic [9:0] BaseCom1  = 10'h3f8;
  localparam logic [9:0] BaseCom2  = 10'h2f8;
  localparam logic [9:0] BaseA0    = 10'h3e8;
  localparam logic [9:0] BaseA1    = 10'h338;
  localparam logic [9:0] BaseA2    = 10'h2e8;
  localparam logic [9:0] BaseA3    = 10'h220;
  localparam logic [9:0] BaseB0    = 10'h2e8;
  localparam logic [9:0] BaseB1    = 10'h238;
  localparam logic [9:0] BaseB2    = 10'h2e0;
  localparam logic [9:0] BaseB3    = 10'h228;
  localparam logic [9:0] BaseLpt1  = 10'h378;
  localparam logic [9:0] BaseLpt2  = 10'h3bc;
  localparam logic [9:0] BaseLpt3  = 10'h278;

  localparam logic [3:0] Irq3 = 4'd3;
  localparam logic [3:0] Irq4 = 4'd4;
  localparam logic [3:0] Irq5 = 4'd5;
  localparam logic [3:0] Irq7 = 4'd7;

  typedef struct packed {
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
    logic [7:0] r25;
    logic [7:0] r27;
    logic [7:0] r28;
  } cfg_view_t;

  typedef struct packed {
    logic [9:0] base;
    logic [3:0] irq;
  } port_res_t;

  typedef struct packed {
    port_res_t uart1;
    port_res_t uart2;
    port_res_t lpt;
  } dec_t;

endpackage

@@ hw/rtl/super_io_config_port_top.sv @@
`timescale 1ns / 1ps

// Index/data configuration port with live resource decode.
// Input channel (in_valid_i/in_ready_o): one bus access per word, given by
// action_i (read/write), port_sel_i (index/data) and write_data_i.
// Output channel (out_valid_o/out_ready_i): one result word per access:
// the byte read (0xff for writes), the decoded serial and parallel port
// bases and IRQs after the access, and the configuration lock flag.
// Latency: the result is valid the cycle after the access is accepted.
// Throughput: one access per cycle; the register file updates and the
// decode settles in the same cycle, feeding a single result register.
// A stalled result holds in the result register; a new access is taken
// in the same cycle the held result leaves, so the input side stalls only
// while the result register is full and not being drained.
// Reset loads the register file defaults, clears the index and the lock,
// arms the 0x88 first index read, and empties the result register.
module super_io_config_port_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic       port_sel_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic [9:0] uart1_base_o,
  output logic [3:0] uart1_irq_o,
  output logic [9:0] uart2_base_o,
  output logic [3:0] uart2_irq_o,
  output logic [9:0] lpt_base_o,
  output logic [3:0] lpt_irq_o,
  output logic       config_locked_o
);
  import sicp_pkg::*;

  logic       acc;
  logic [7:0] rd;
  cfg_view_t  view;
  logic       lock;
  dec_t       dec;

  logic       valid_q;
  logic [7:0] rd_q;
  dec_t       dec_q;
  logic       lock_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  sicp_regfile u_regfile (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .action_i     (action_i),
    .port_sel_i   (port_sel_i),
    .write_data_i (write_data_i),
    .read_data_o  (rd),
    .view_o       (view),
    .lock_o       (lock)
  );

  sicp_decode u_decode (
    .view_i (view),
    .dec_o  (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rd_q    <= '0;
      dec_q   <= '0;
      lock_q  <= 1'b0;
    end else begin
      if (acc) begin
        valid_q <= 1'b1;
        rd_q    <= rd;
        dec_q   <= dec;
        lock_q  <= lock;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign read_data_o     = rd_q;
  assign uart1_base_o    = dec_q.uart1.base;
  assign uart1_irq_o     = dec_q.uart1.irq;
  assign uart2_base_o    = dec_q.uart2.base;
  assign uart2_irq_o     = dec_q.uart2.irq;
  assign lpt_base_o      = dec_q.lpt.base;
  assign lpt_irq_o       = dec_q.lpt.irq;
  assign config_locked_o = lock_q;

endmodule

@@ hw/rtl/sicp_regfile.sv @@
`timescale 1ns / 1ps

module sicp_regfile (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic                action_i,
  input  logic                port_sel_i,
  input  logic [7:0]          write_data_i,
  output logic [7:0]          read_data_o,
  output sicp_pkg::cfg_view_t view_o,
  output logic                lock_o
);
  import sicp_pkg::*;

  typedef enum logic [1:0] {
    TryReset,
    TrySecond,
    TryZero,
    TryOne
  } try_e;

  cfg_file_t       cfg_q, cfg_d;
  logic [IdxW-1:0] idx_q, idx_d;
  try_e            try_q, try_d;
  logic            lock_q, lock_d;
  logic [7:0]      rd;

  always_comb begin
    logic [7:0] diff;
    diff   = '0;
    cfg_d  = cfg_q;
    idx_d  = idx_q;
    try_d  = try_q;
    lock_d = lock_q;
    rd     = IdleByte;
    if (acc_i) begin
      if (action_i == ActWrite) begin
        if (port_sel_i == PortIndex) begin
          idx_d = write_data_i[IdxW-1:0];
          try_d = TryZero;
        end else if (try_q == TryZero) begin
          try_d = TryOne;
        end else if (!lock_q) begin
          try_d = TryZero;
          if (idx_q <= WriteLimit && idx_q != IdReg) begin
            diff         = write_data_i ^ cfg_q[idx_q];
            cfg_d[idx_q] = write_data_i;
            if (idx_q == LockReg && diff[LockBit]) begin
              lock_d = write_data_i[LockBit];
            end
            if (idx_q == LptCtlReg && diff[6:4] != 3'b000 && !write_data_i[6]) begin
              cfg_d[LptBaseReg] = Reg25Default;
            end
          end
        end
      end else if (port_sel_i == PortIndex) begin
        unique case (try_q)
          TryReset: begin
            rd    = IdxFirstRead;
            try_d = TrySecond;
          end
          TrySecond: begin
            rd    = 8'h00;
            try_d = TryZero;
          end
          default: begin
            rd    = {{(8-IdxW){1'b0}}, idx_q};
            try_d = TryZero;
          end
        endcase
      end else begin
        try_d = TryZero;
        if (idx_q == IdReg) begin
          rd = IdValue;
        end else if (idx_q < ReadLimit) begin
          rd = cfg_q[idx_q];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= CfgReset;
      idx_q  <= '0;
      try_q  <= TryReset;
      lock_q <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      idx_q  <= idx_d;
      try_q  <= try_d;
      lock_q <= lock_d;
    end
  end

  // decode looks at the state as it stands after this access
  assign read_data_o = rd;
  assign lock_o      = lock_d;
  assign view_o      = '{r0: cfg_d[0], r1: cfg_d[1], r2: cfg_d[2],
                         r25: cfg_d[25], r27: cfg_d[27], r28: cfg_d[28]};

endmodule

@@ hw/rtl/sicp_decode.sv @@
`timescale 1ns / 1ps

module sicp_decode (
  input  sicp_pkg::cfg_view_t view_i,
  output sicp_pkg::dec_t      dec_o
);
  import sicp_pkg::*;

  function automatic port_res_t uart_dec(logic en, logic [1:0] sel, logic [1:0] hi,
                                         logic irq_ovr, logic irq_bit);
    port_res_t r;
    r.base = '0;
    r.irq  = '0;
    if (en) begin
      unique case (sel)
        2'd0: r.base = BaseCom1;
        2'd1: r.base = BaseCom2;
        2'd2: begin
          unique case (hi)
            2'd0: r.base = BaseA0;
            2'd1: r.base = BaseA1;
            2'd2: r.base = BaseA2;
            default: r.base = BaseA3;
          endcase
        end
        default: begin
          unique case (hi)
            2'd0: r.base = BaseB0;
            2'd1: r.base = BaseB1;
            2'd2: r.base = BaseB2;
            default: r.base = BaseB3;
          endcase
        end
      endcase
      if (irq_ovr) begin
        r.irq = irq_bit ? Irq4 : Irq3;
      end else begin
        r.irq = sel[0] ? Irq3 : Irq4;
      end
    end
    return r;
  endfunction

  port_res_t lpt;

  always_comb begin
    lpt.base = '0;
    lpt.irq  = '0;
    unique case (view_i.r1[1:0])
      2'd0: begin
        lpt.base = BaseLpt1;
        lpt.irq  = view_i.r2[3] ? Irq7 : Irq5;
      end
      2'd1: begin
        lpt.base = view_i.r27[6] ? {view_i.r25, 2'b00} : BaseLpt2;
        lpt.irq  = Irq7;
      end
      2'd2: begin
        lpt.base = BaseLpt3;
        lpt.irq  = Irq5;
      end
      default: begin
        lpt.base = '0;
        lpt.irq  = '0;
      end
    endcase
    if (!view_i.r0[0]) begin
      lpt.base = '0;
    end
    if (view_i.r27[4]) begin
      lpt.irq = view_i.r27[5] ? Irq7 : Irq5;
    end
    if (lpt.base == '0) begin
      lpt.irq = '0;
    end
  end

  assign dec_o.uart1 = uart_dec(view_i.r0[1], view_i.r1[3:2], view_i.r1[7:6],
                                view_i.r28[0], view_i.r28[2]);
  assign dec_o.uart2 = uart_dec(view_i.r0[2], view_i.r1[5:4], view_i.r1[7:6],
                                view_i.r28[0], view_i.r28[6]);
  assign dec_o.lpt   = lpt;

endmodule

@@ hw/rtl/sicp_checker.sv @@
`timescale 1ns / 1ps

module sicp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o,
  input logic [9:0] uart1_base_o,
  input logic [3:0] uart1_irq_o,
  input logic [9:0] lpt_base_o,
  input logic [3:0] lpt_irq_o,
  input logic       config_locked_o
);

  // held word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o))
    else $error("result word changed while stalled");

  // input side stalls only behind a full, stalled result register
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // lock is sticky until reset
  a_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    config_locked_o |=> config_locked_o)
    else $error("config lock dropped");

  a_lpt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lpt_irq_o != 4'd0 |-> lpt_base_o != 10'd0)
    else $error("parallel IRQ without base");

  a_uart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uart1_base_o == 10'd0) == (uart1_irq_o == 4'd0))
    else $error("serial base and IRQ disagree on enable");

endmodule

bind super_io_config_port_top sicp_checker u_sicp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .read_data_o     (read_data_o),
  .uart1_base_o    (uart1_base_o),
  .uart1_irq_o     (uart1_irq_o),
  .lpt_base_o      (lpt_base_o),
  .lpt_irq_o       (lpt_irq_o),
  .config_locked_o (config_locked_o)
);
